FILE: rtl/core/altimeter_flight_phase_detector_defines.svh
// assertion macros shared by the flight phase detector
`ifndef ALTIMETER_FLIGHT_PHASE_DETECTOR_DEFINES_SVH
`define ALTIMETER_FLIGHT_PHASE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define AFPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AFPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/afpd_pkg.sv
package afpd_pkg;

  // field and datapath widths, sized for the largest calibration count
  localparam int ALT_W    = 21;
  localparam int CFG_W    = 14;
  localparam int RUN_W    = 16;
  localparam int IDX_W    = 6;
  localparam int SCALED_W = 28;
  localparam int DIFF_W   = SCALED_W + 1;
  localparam int THR_W    = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APOGEE_DROP   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANDED_HEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANDED_RUN    = 8'd3;

  // register reset values, unscaled
  localparam int LAUNCH_HEIGHT_RST = 200;
  localparam int APOGEE_DROP_RST   = 50;
  localparam int LANDED_HEIGHT_RST = 50;
  localparam int LANDED_RUN_RST    = 500;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ASCENT  = 3'd1,
    PH_APOGEE  = 3'd2,
    PH_DESCENT = 3'd3,
    PH_LANDED  = 3'd4
  } phase_t;

  // thresholds already multiplied by the calibration count
  typedef struct packed {
    logic [THR_W-1:0] launch_s;
    logic [THR_W-1:0] drop_s;
    logic [THR_W-1:0] landed_s;
    logic [RUN_W-1:0] run_need;
  } afpd_cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   calibrating;
    logic   launch_ev;
    logic   apogee_ev;
    logic   landed_ev;
  } afpd_res_t;

endpackage

FILE: rtl/core/afpd_cfg_regs.sv
module afpd_cfg_regs #(
  parameter int CALIB_SAMPLES = 50
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [afpd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [afpd_pkg::CFG_DATA_W-1:0]  wr_data,
  output afpd_pkg::afpd_cfg_t              cfg
);
  import afpd_pkg::*;

  logic [THR_W-1:0] launch_s_r, drop_s_r, landed_s_r;
  logic [RUN_W-1:0] run_need_r;
  logic [THR_W-1:0] wr_scaled;

  // thresholds are kept scaled by the calibration count
  assign wr_scaled = THR_W'(wr_data[CFG_W-1:0]) * THR_W'(CALIB_SAMPLES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_s_r <= THR_W'(LAUNCH_HEIGHT_RST * CALIB_SAMPLES);
      drop_s_r   <= THR_W'(APOGEE_DROP_RST * CALIB_SAMPLES);
      landed_s_r <= THR_W'(LANDED_HEIGHT_RST * CALIB_SAMPLES);
      run_need_r <= RUN_W'(LANDED_RUN_RST);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LAUNCH_HEIGHT: launch_s_r <= wr_scaled;
        REG_APOGEE_DROP:   drop_s_r   <= wr_scaled;
        REG_LANDED_HEIGHT: landed_s_r <= wr_scaled;
        // a zero run length behaves as one
        REG_LANDED_RUN: begin
          run_need_r <= (wr_data[RUN_W-1:0] == '0) ? RUN_W'(1) : wr_data[RUN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg.launch_s = launch_s_r;
  assign cfg.drop_s   = drop_s_r;
  assign cfg.landed_s = landed_s_r;
  assign cfg.run_need = run_need_r;

endmodule

FILE: rtl/core/afpd_in_stage.sv
module afpd_in_stage #(
  parameter int CALIB_SAMPLES = 50
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [afpd_pkg::ALT_W-1:0]     in_alt,
  input  logic                                  advance,
  output logic                                  s1_valid,
  output logic signed [afpd_pkg::ALT_W-1:0]     s1_alt,
  output logic signed [afpd_pkg::SCALED_W-1:0]  s1_alt_s
);
  import afpd_pkg::*;

  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [ALT_W-1:0]    alt_r;
  logic signed [SCALED_W-1:0] alt_s_r, alt_s_nxt;
  logic                       in_xfer;

  // stage is free when empty or when its item moves on this cycle
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // sample scaled by the calibration count, same scale as the ground sum
  assign alt_s_nxt = SCALED_W'(in_alt) * $signed(SCALED_W'(CALIB_SAMPLES));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      alt_r   <= in_alt;
      alt_s_r <= alt_s_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_alt   = alt_r;
  assign s1_alt_s = alt_s_r;

endmodule

FILE: rtl/core/afpd_phase_core.sv
`include "altimeter_flight_phase_detector_defines.svh"

module afpd_phase_core #(
  parameter int CALIB_SAMPLES = 50
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic signed [afpd_pkg::ALT_W-1:0]     alt,
  input  logic signed [afpd_pkg::SCALED_W-1:0]  alt_s,
  input  afpd_pkg::afpd_cfg_t                   cfg,
  output afpd_pkg::afpd_res_t                   res
);
  import afpd_pkg::*;

  logic                       calib_done_r, calib_done_nxt;
  logic [IDX_W-1:0]           calib_index_r, calib_index_nxt;
  logic signed [SCALED_W-1:0] ground_sum_r, ground_sum_nxt;
  phase_t                     phase_r, phase_nxt;
  logic signed [SCALED_W-1:0] peak_r, peak_nxt;
  logic [RUN_W-1:0]           low_run_r, low_run_nxt;

  logic signed [SCALED_W-1:0] sum_add;
  logic [IDX_W-1:0]           idx_inc;
  logic signed [DIFF_W-1:0]   agl_s;
  logic signed [SCALED_W-1:0] peak_hi;
  logic signed [DIFF_W-1:0]   drop_s;
  logic [RUN_W-1:0]           run_inc;
  logic                       launch_hit, apogee_hit, low_hit;

  // shared arithmetic for the calibration and phase paths
  assign sum_add    = ground_sum_r + SCALED_W'(alt);
  assign idx_inc    = calib_index_r + IDX_W'(1);
  assign agl_s      = DIFF_W'(alt_s) - DIFF_W'(ground_sum_r);
  assign peak_hi    = (alt_s > peak_r) ? alt_s : peak_r;
  assign drop_s     = DIFF_W'(peak_hi) - DIFF_W'(alt_s);
  assign run_inc    = (low_run_r == '1) ? low_run_r : low_run_r + RUN_W'(1);
  assign launch_hit = agl_s >= $signed(DIFF_W'(cfg.launch_s));
  assign apogee_hit = drop_s >= $signed(DIFF_W'(cfg.drop_s));
  assign low_hit    = agl_s <= $signed(DIFF_W'(cfg.landed_s));

  // next state and result of the current sample
  always_comb begin
    calib_done_nxt  = calib_done_r;
    calib_index_nxt = calib_index_r;
    ground_sum_nxt  = ground_sum_r;
    phase_nxt       = phase_r;
    peak_nxt        = peak_r;
    low_run_nxt     = low_run_r;
    res.calibrating = 1'b0;
    res.launch_ev   = 1'b0;
    res.apogee_ev   = 1'b0;
    res.landed_ev   = 1'b0;
    if (!calib_done_r) begin
      ground_sum_nxt  = sum_add;
      calib_index_nxt = idx_inc;
      res.calibrating = 1'b1;
      if (idx_inc >= IDX_W'(CALIB_SAMPLES)) begin
        calib_done_nxt = 1'b1;
        peak_nxt       = sum_add;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (launch_hit) begin
            phase_nxt     = PH_ASCENT;
            res.launch_ev = 1'b1;
          end
        end
        PH_ASCENT: begin
          peak_nxt = peak_hi;
          if (apogee_hit) begin
            phase_nxt     = PH_APOGEE;
            res.apogee_ev = 1'b1;
          end
        end
        PH_APOGEE: phase_nxt = PH_DESCENT;
        PH_DESCENT: begin
          if (low_hit) begin
            low_run_nxt = run_inc;
            if (run_inc >= cfg.run_need) begin
              phase_nxt     = PH_LANDED;
              res.landed_ev = 1'b1;
            end
          end else begin
            low_run_nxt = '0;
          end
        end
        // landed and unused codes hold
        default: ;
      endcase
    end
    res.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_done_r  <= 1'b0;
      calib_index_r <= '0;
      ground_sum_r  <= '0;
      phase_r       <= PH_IDLE;
      peak_r        <= '0;
      low_run_r     <= '0;
    end else if (step) begin
      calib_done_r  <= calib_done_nxt;
      calib_index_r <= calib_index_nxt;
      ground_sum_r  <= ground_sum_nxt;
      phase_r       <= phase_nxt;
      peak_r        <= peak_nxt;
      low_run_r     <= low_run_nxt;
    end
  end

  // checks on the phase sequencing
  `AFPD_ASSERT_IMP(a_one_event, clk, rst_n, step, $onehot0({res.launch_ev, res.apogee_ev, res.landed_ev}), "more than one event on a sample")
  `AFPD_ASSERT_IMP(a_calib_idle, clk, rst_n, !calib_done_r, phase_r == PH_IDLE, "phase left idle during calibration")
  `AFPD_ASSERT_IMP(a_launch_src, clk, rst_n, step && res.launch_ev, calib_done_r && phase_r == PH_IDLE, "launch outside ground idle")
  `AFPD_ASSERT_NXT(a_apogee_pass, clk, rst_n, step && calib_done_r && phase_r == PH_APOGEE, phase_r == PH_DESCENT, "apogee did not pass to descent")

endmodule

FILE: rtl/core/altimeter_flight_phase_detector.sv
// a sample is held in the input register, then its result is held in the result register
// throughput: one sample per cycle while out_ready does not hold the result register, with the
// phase update running combinationally between the input register and the result register
// reset (rst_n low, synchronous) clears calibration, phase and peak state,
// empties both pipeline registers and returns the thresholds to their defaults
module altimeter_flight_phase_detector #(
  parameter int CALIB_SAMPLES = 50
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [afpd_pkg::ALT_W-1:0]    in_altitude_dm,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_phase,
  output logic                                 out_calibrating,
  output logic                                 out_launch_event,
  output logic                                 out_apogee_event,
  output logic                                 out_landed_event,
  output logic                                 out_fast_rate,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [afpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import afpd_pkg::*;

  afpd_cfg_t                  cfg;
  afpd_res_t                  res;
  logic                       advance, step;
  logic                       s1_valid;
  logic signed [ALT_W-1:0]    s1_alt;
  logic signed [SCALED_W-1:0] s1_alt_s;
  logic                       out_valid_r, out_valid_nxt;
  afpd_res_t                  res_r;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  afpd_cfg_regs #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register frees when empty or when its transfer completes
  assign advance = !out_valid_r || out_ready;
  assign step    = s1_valid && advance;

  afpd_in_stage #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_alt   (in_altitude_dm),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_alt   (s1_alt),
    .s1_alt_s (s1_alt_s)
  );

  afpd_phase_core #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .alt   (s1_alt),
    .alt_s (s1_alt_s),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = res_r.phase;
  assign out_calibrating  = res_r.calibrating;
  assign out_launch_event = res_r.launch_ev;
  assign out_apogee_event = res_r.apogee_ev;
  assign out_landed_event = res_r.landed_ev;
  assign out_fast_rate    = (res_r.phase != PH_IDLE);

endmodule

FILE: verif/altimeter_flight_phase_detector_test.sv
`timescale 1ns / 1ps

module altimeter_flight_phase_detector_test;
  import afpd_pkg::*;

  localparam int CALIB_N = 50;
  localparam int SEGMENTS = 10;
  localparam int SEG_SAMPLES = 75;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint ALT_MAX = 1048575;
  localparam longint ALT_MIN = -1048576;

  typedef struct {
    phase_t phase;
    bit     calibrating;
    bit     launch_event;
    bit     apogee_event;
    bit     landed_event;
    bit     fast_rate;
  } flight_report_t;

  // directed stimulus: typed rows carry their own expectation (no events set)
  typedef struct {
    int     alt;
    int     reps;
    bit     typed;
    phase_t exp_phase;
    bit     exp_calib;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [ALT_W-1:0]       in_altitude_dm = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    out_phase;
  logic                          out_calibrating;
  logic                          out_launch_event;
  logic                          out_apogee_event;
  logic                          out_landed_event;
  logic                          out_fast_rate;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  // thresholds as the block should hold them
  logic [CFG_W-1:0]  launch_dm = CFG_W'(LAUNCH_HEIGHT_RST);
  logic [CFG_W-1:0]  drop_dm   = CFG_W'(APOGEE_DROP_RST);
  logic [CFG_W-1:0]  landed_dm = CFG_W'(LANDED_HEIGHT_RST);
  logic [RUN_W-1:0]  run_need  = RUN_W'(LANDED_RUN_RST);

  // flight state tracked alongside the block
  bit      ground_ready = 1'b0;
  int      calib_seen = 0;
  longint  gnd_sum = 0;
  phase_t  phase_now = PH_IDLE;
  longint  peak_s = 0;
  int      low_run = 0;

  flight_report_t flight_reports_due[$];
  int unsigned    fail_count = 0;
  int unsigned    idle_pct = 22;
  int unsigned    quiet_cycles = 0;

  phase_t seg_goal [SEGMENTS] = '{PH_IDLE, PH_IDLE, PH_ASCENT, PH_ASCENT, PH_DESCENT,
                                  PH_DESCENT, PH_DESCENT, PH_LANDED, PH_LANDED, PH_LANDED};

  // calibration with both field extremes, then ground idle around the launch edge
  stim_row_t directed_rows [7] = '{
    '{1048575,  1,  1'b1, PH_IDLE, 1'b1},
    '{-1048576, 1,  1'b1, PH_IDLE, 1'b1},
    '{1000,     48, 1'b1, PH_IDLE, 1'b1},
    '{-1048576, 1,  1'b1, PH_IDLE, 1'b0},
    '{1159,     1,  1'b0, PH_IDLE, 1'b0},
    '{0,        1,  1'b0, PH_IDLE, 1'b0},
    '{960,      1,  1'b0, PH_IDLE, 1'b0}
  };

  altimeter_flight_phase_detector #(
    .CALIB_SAMPLES(CALIB_N)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_altitude_dm   (in_altitude_dm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_phase        (out_phase),
    .out_calibrating  (out_calibrating),
    .out_launch_event (out_launch_event),
    .out_apogee_event (out_apogee_event),
    .out_landed_event (out_landed_event),
    .out_fast_rate    (out_fast_rate),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // floor division by the calibration count
  function automatic longint floor_n(longint x);
    longint q;
    q = x / CALIB_N;
    if ((x % CALIB_N != 0) && (x < 0)) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint clamp_alt(longint v);
    if (v > ALT_MAX) begin
      return ALT_MAX;
    end
    if (v < ALT_MIN) begin
      return ALT_MIN;
    end
    return v;
  endfunction

  // distance from a boundary: mostly close, sometimes across the whole field
  function automatic longint spread();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 100);
      2: return $urandom_range(0, 5000);
      default: return $urandom_range(0, 2100000);
    endcase
  endfunction

  // next phase and flags for one altitude sample
  function automatic flight_report_t advance_flight(logic signed [ALT_W-1:0] alt);
    flight_report_t rep;
    longint a;
    longint a_s;
    longint agl_s;
    int need;
    a = alt;
    a_s = a * CALIB_N;
    rep = '{PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    if (!ground_ready) begin
      gnd_sum = gnd_sum + a;
      calib_seen = (calib_seen + 1) & 63;
      rep.calibrating = 1'b1;
      if (calib_seen >= CALIB_N) begin
        ground_ready = 1'b1;
        peak_s = gnd_sum;
      end
    end else begin
      agl_s = a_s - gnd_sum;
      need = (run_need == 0) ? 1 : int'(run_need);
      case (phase_now)
        PH_IDLE: begin
          if (agl_s >= longint'(launch_dm) * CALIB_N) begin
            phase_now = PH_ASCENT;
            rep.launch_event = 1'b1;
          end
        end
        PH_ASCENT: begin
          if (a_s > peak_s) begin
            peak_s = a_s;
          end
          if (peak_s - a_s >= longint'(drop_dm) * CALIB_N) begin
            phase_now = PH_APOGEE;
            rep.apogee_event = 1'b1;
          end
        end
        PH_APOGEE: begin
          phase_now = PH_DESCENT;
        end
        PH_DESCENT: begin
          if (agl_s <= longint'(landed_dm) * CALIB_N) begin
            if (low_run < 65535) begin
              low_run = low_run + 1;
            end
            if (low_run >= need) begin
              phase_now = PH_LANDED;
              rep.landed_event = 1'b1;
            end
          end else begin
            low_run = 0;
          end
        end
        default: ;
      endcase
    end
    rep.phase = phase_now;
    rep.fast_rate = (phase_now != PH_IDLE);
    return rep;
  endfunction

  // altitude that keeps the flight in its phase, or moves it on when the goal allows
  function automatic logic signed [ALT_W-1:0] pick_altitude(phase_t goal);
    longint lim;
    longint v;
    int need;
    logic [ALT_W-1:0] raw;
    raw = ALT_W'($urandom);
    v = longint'($signed(raw));
    case (phase_now)
      PH_IDLE: begin
        lim = -floor_n(-(longint'(launch_dm) * CALIB_N + gnd_sum));
        if (goal >= PH_ASCENT && $urandom_range(0, 7) == 0) begin
          v = ($urandom_range(0, 1) == 0) ? lim : lim + spread();
        end else begin
          v = lim - 1 - spread();
        end
      end
      PH_ASCENT: begin
        lim = floor_n(peak_s - longint'(drop_dm) * CALIB_N);
        if (goal >= PH_APOGEE && $urandom_range(0, 7) == 0) begin
          v = lim - spread();
        end else begin
          v = lim + 1 + spread();
        end
      end
      PH_DESCENT: begin
        lim = floor_n(longint'(landed_dm) * CALIB_N + gnd_sum);
        need = (run_need == 0) ? 1 : int'(run_need);
        if ((goal < PH_LANDED && (low_run + 1 >= need || $urandom_range(0, 5) == 0)) ||
            (goal == PH_LANDED && $urandom_range(0, 19) == 0)) begin
          v = lim + 1 + spread();
        end else begin
          v = lim - spread();
        end
      end
      default: ;
    endcase
    return ALT_W'(clamp_alt(v));
  endfunction

  // one sample transfer, with random gaps before it
  task automatic send_sample(logic signed [ALT_W-1:0] alt);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_altitude_dm <= alt;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write; valid is left high so back-to-back writes need no second drive
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LAUNCH_HEIGHT: launch_dm = data[CFG_W-1:0];
      REG_APOGEE_DROP:   drop_dm = data[CFG_W-1:0];
      REG_LANDED_HEIGHT: landed_dm = data[CFG_W-1:0];
      REG_LANDED_RUN:    run_need = data[RUN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(10000);
      2: return CFG_DATA_W'($urandom_range(0, 16383));
      default: return CFG_DATA_W'($urandom_range(1, 400));
    endcase
  endfunction

  // thresholds for the next segment: low extremes, high extremes, then random
  task automatic setup_thresholds(int seg, phase_t goal);
    logic [CFG_DATA_W-1:0] lh;
    logic [CFG_DATA_W-1:0] dr;
    logic [CFG_DATA_W-1:0] ld;
    logic [CFG_DATA_W-1:0] rn;
    logic [CFG_IDX_W-1:0]  stray_idx;
    if (seg == 0) begin
      lh = '0; dr = '0; ld = '0; rn = '0;
    end else if (seg == 1) begin
      lh = 16'd10000; dr = 16'd10000; ld = 16'd10000; rn = 16'hFFFF;
    end else begin
      lh = pick_height();
      dr = pick_height();
      ld = pick_height();
      rn = CFG_DATA_W'($urandom_range(1, 24));
      // no drop at all would force apogee while ascent is meant to last
      if (goal == PH_ASCENT && dr == 0) begin
        dr = 16'd1;
      end
      if (goal != PH_LANDED && $urandom_range(0, 5) == 0) begin
        rn = 16'hFFFF;
      end
      // zero run length lands on the first low sample
      if (seg == 7) begin
        rn = '0;
      end
    end
    write_reg(REG_LAUNCH_HEIGHT, lh);
    write_reg(REG_APOGEE_DROP, dr);
    write_reg(REG_LANDED_HEIGHT, ld);
    write_reg(REG_LANDED_RUN, rn);
    // out-of-range index must leave every threshold alone
    if (seg == 0 || $urandom_range(0, 1) == 0) begin
      stray_idx = CFG_IDX_W'(REG_LANDED_RUN + 1 + $urandom_range(0, 251));
      write_reg(stray_idx, CFG_DATA_W'($urandom_range(0, 65535)));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result side: random back-pressure and checking of each transfer
  always @(posedge clk) begin
    flight_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (flight_reports_due.size() == 0) begin
        $error("result with no sample outstanding: phase %0d", out_phase);
        fail_count++;
      end else begin
        want = flight_reports_due.pop_front();
        compare_field("phase", want.phase, out_phase);
        compare_field("calibrating", want.calibrating, out_calibrating);
        compare_field("launch_event", want.launch_event, out_launch_event);
        compare_field("apogee_event", want.apogee_event, out_apogee_event);
        compare_field("landed_event", want.landed_event, out_landed_event);
        compare_field("fast_rate", want.fast_rate, out_fast_rate);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [ALT_W-1:0] alt;
    flight_report_t rep;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, reset thresholds
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        alt = ALT_W'(directed_rows[r].alt);
        send_sample(alt);
        rep = advance_flight(alt);
        if (directed_rows[r].typed) begin
          rep = '{directed_rows[r].exp_phase, directed_rows[r].exp_calib,
                  1'b0, 1'b0, 1'b0, 1'b0};
        end
        flight_reports_due.push_back(rep);
      end
    end
    in_valid <= 1'b0;
    while (flight_reports_due.size() != 0) @(posedge clk);

    // one flight, segment by segment, thresholds changed while drained
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      setup_thresholds(seg, seg_goal[seg]);
      idle_pct = (seg == 5) ? 0 : 22;
      repeat (SEG_SAMPLES) begin
        alt = pick_altitude(seg_goal[seg]);
        send_sample(alt);
        flight_reports_due.push_back(advance_flight(alt));
      end
      in_valid <= 1'b0;
      while (flight_reports_due.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: altimeter_flight_phase_detector.f
+incdir+rtl/core
rtl/core/afpd_pkg.sv
rtl/core/afpd_cfg_regs.sv
rtl/core/afpd_in_stage.sv
rtl/core/afpd_phase_core.sv
rtl/core/altimeter_flight_phase_detector.sv
verif/altimeter_flight_phase_detector_test.sv
